>>> rtl/pi_pkg.sv
// ----------------------------------------------------------------------------
// pi_pkg
// Shared types, codes and the tanh table for the perceptron block.
// ----------------------------------------------------------------------------
package pi_pkg;

  localparam int OPCODE_W   = 2;
  localparam int SLOT_W     = 8;
  localparam int VALUE_W    = 16;
  localparam int INDEX_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OP_WEIGHT  = 2'd0;
  localparam opcode_t OP_FEATURE = 2'd1;
  localparam opcode_t OP_TARGET  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE    = 2'd3;

  localparam logic KIND_OUTPUT     = 1'b0;
  localparam logic KIND_ERROR      = 1'b1;
  localparam logic MODE_REGRESSION = 1'b1;

  // last table point, tanh saturates from here on
  localparam int TANH_LAST = 24;

  // tanh at steps of 0.25, Q1.15
  function automatic logic [15:0] tanh_q15(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'd0;
      5'd1:    r = 16'd8025;
      5'd2:    r = 16'd15143;
      5'd3:    r = 16'd20813;
      5'd4:    r = 16'd24956;
      5'd5:    r = 16'd27797;
      5'd6:    r = 16'd29660;
      5'd7:    r = 16'd30847;
      5'd8:    r = 16'd31589;
      5'd9:    r = 16'd32048;
      5'd10:   r = 16'd32329;
      5'd11:   r = 16'd32501;
      5'd12:   r = 16'd32606;
      5'd13:   r = 16'd32670;
      5'd14:   r = 16'd32708;
      5'd15:   r = 16'd32732;
      5'd16:   r = 16'd32746;
      5'd17:   r = 16'd32755;
      5'd18:   r = 16'd32760;
      5'd19:   r = 16'd32763;
      5'd20:   r = 16'd32765;
      5'd21:   r = 16'd32766;
      5'd22:   r = 16'd32767;
      5'd23:   r = 16'd32767;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pi_if.sv
// ----------------------------------------------------------------------------
// pi_in_if / pi_out_if
// Valid/ready channels carrying the perceptron request and result items.
// ----------------------------------------------------------------------------
interface pi_in_if;
  logic                                valid;
  logic                                ready;
  logic        [pi_pkg::OPCODE_W-1:0]  opcode;
  logic        [pi_pkg::SLOT_W-1:0]    slot;
  logic signed [pi_pkg::VALUE_W-1:0]   value;
  logic                                final_req;

  modport source(output valid, opcode, slot, value, final_req, input ready);
  modport sink(input valid, opcode, slot, value, final_req, output ready);
endinterface

interface pi_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic        [pi_pkg::INDEX_W-1:0]   out_index;
  logic signed [pi_pkg::VALUE_W-1:0]   result_value;
  logic                                run_end;

  modport source(output valid, kind, out_index, result_value, run_end, input ready);
  modport sink(input valid, kind, out_index, result_value, run_end, output ready);
endinterface

>>> rtl/perceptron_infer_and_update.sv
// ----------------------------------------------------------------------------
// perceptron_infer_and_update
// Single-layer perceptron, Q4.12 by default: inference and delta-rule update.
// ----------------------------------------------------------------------------
// in_ch carries weight writes, feature values and training targets; out_ch
// carries output values and training errors. cfg_we/cfg_index/cfg_data write
// mode, inputs in use, outputs in use and learning rate; the user must write
// them only while idle, the block does not enforce it. A feature transaction
// with final_req evaluates every output in use: per output, read, multiply
// and accumulate for each input and the bias, then rounding (and tanh), then
// one result transaction. A target transaction for an output in use walks
// its row with read, multiply, accumulate and write-back per input and the
// bias and returns one error result. All of this runs through one
// multiply-accumulate datapath and the single read port of the weight RAM,
// under one sequencer; no new transaction is taken until the last result of
// the previous one has gone. Reset clears the configuration to its defaults,
// idles the sequencer and zeroes the stored outputs; weights and features
// must be written before use. When out_ch stalls the result is held in its
// output register and the sequencer waits.
// ----------------------------------------------------------------------------
module perceptron_infer_and_update #(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_OUTPUTS = 8,
  parameter int FRAC_BITS   = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  pi_in_if.sink                           in_ch,
  pi_out_if.source                        out_ch,
  input  logic                            cfg_we,
  input  logic [pi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pi_pkg::*;

  localparam int ROW_STRIDE   = MAX_INPUTS + 1;
  localparam int WEIGHT_DEPTH = ROW_STRIDE * MAX_OUTPUTS;
  localparam int WA_W   = WEIGHT_DEPTH > 1 ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int FA_W   = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
  localparam int C_W    = $clog2(MAX_INPUTS + 1);
  localparam int NO_CAP = MAX_OUTPUTS < 8 ? MAX_OUTPUTS : 8;
  localparam int O_W    = NO_CAP > 1 ? $clog2(NO_CAP) : 1;
  localparam int NO_W   = $clog2(NO_CAP + 1);
  localparam int PROD_W = (16 + FRAC_BITS > 32) ? 16 + FRAC_BITS : 32;
  localparam int ACC_W  = PROD_W + $clog2(MAX_INPUTS + 1) + 1;
  localparam int M1_W   = 33;
  localparam int M2_W   = M1_W + 13;
  localparam int STEP   = FRAC_BITS - 2;
  localparam int TP_W   = 14 + STEP;
  localparam int DN     = FRAC_BITS < 15 ? 15 - FRAC_BITS : 1;
  localparam int UP     = FRAC_BITS >= 15 ? FRAC_BITS - 15 : 0;
  localparam int Y_W    = 18 + UP;

  localparam logic signed [ACC_W-1:0]  ACC_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]  ACC_MIN = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [M2_W:0]     WB_MAX = (M2_W + 1)'(32767);
  localparam logic signed [M2_W:0]     WB_MIN = -(M2_W + 1)'(32768);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_RND  = 4'd5;
  localparam logic [3:0] S_T1   = 4'd6;
  localparam logic [3:0] S_T2   = 4'd7;
  localparam logic [3:0] S_T3   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  // configuration
  logic        mode;
  logic [4:0]  inputs_in_use;
  logic [3:0]  outputs_in_use;
  logic [11:0] learn_rate;

  logic [C_W-1:0]  ni;
  logic [NO_W-1:0] no;

  always_comb begin
    if (inputs_in_use == 5'd0) begin
      ni = C_W'(1);
    end else if (32'(inputs_in_use) > MAX_INPUTS) begin
      ni = C_W'(MAX_INPUTS);
    end else begin
      ni = C_W'(inputs_in_use);
    end
    if (outputs_in_use == 4'd0) begin
      no = NO_W'(1);
    end else if (32'(outputs_in_use) > NO_CAP) begin
      no = NO_W'(NO_CAP);
    end else begin
      no = NO_W'(outputs_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 1'b0;
      inputs_in_use  <= 5'd16;
      outputs_in_use <= 4'd1;
      learn_rate     <= 12'd41;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    mode           <= cfg_data[0];
        REG_INPUTS:  inputs_in_use  <= cfg_data[4:0];
        REG_OUTPUTS: outputs_in_use <= cfg_data[3:0];
        REG_RATE:    learn_rate     <= cfg_data[11:0];
        default:     ;
      endcase
    end
  end

  // sequencer state
  logic [3:0]             state;
  logic                   eval;
  logic [C_W-1:0]         col;
  logic [O_W-1:0]         oidx;
  logic [WA_W-1:0]        row_base;
  logic signed [ACC_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [M1_W-1:0] m1;
  logic signed [M2_W-1:0] m2;
  logic signed [16:0]     diff;
  logic signed [15:0]     err;
  logic signed [15:0]     wcur;
  logic signed [15:0]     sval;
  logic [15:0]            tlo;
  logic [TP_W-1:0]        tprod;
  logic                   tsat;
  logic                   tneg;
  logic [16:0]            ty;
  logic signed [15:0]     ostore [NO_CAP];

  logic                   res_kind;
  logic [INDEX_W-1:0]     res_idx;
  logic signed [15:0]     res_val;
  logic                   res_last;

  logic is_bias;
  assign is_bias = (col == ni);

  // memories
  logic              w_we;
  logic [WA_W-1:0]   w_waddr;
  logic [15:0]       w_wdata;
  logic [WA_W-1:0]   w_raddr;
  logic [15:0]       w_rdata;
  logic              f_we;
  logic [15:0]       f_rdata;
  logic [WA_W-1:0]   row_addr;

  assign row_addr = row_base + (is_bias ? WA_W'(MAX_INPUTS) : WA_W'(col));
  assign w_raddr  = row_addr;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign f_we = accept && (in_ch.opcode == OP_FEATURE) && (32'(in_ch.slot) < MAX_INPUTS);

  // new weight after a training step
  logic signed [M2_W:0] delta;
  logic signed [M2_W:0] wsum;
  logic signed [15:0]   wnew;

  always_comb begin
    if (is_bias) begin
      delta = (M2_W + 1)'((m2 + (M2_W'(1) <<< 11)) >>> 12);
    end else begin
      delta = (M2_W + 1)'((m2 + (M2_W'(1) <<< (11 + FRAC_BITS))) >>> (12 + FRAC_BITS));
    end
    wsum = (M2_W + 1)'(wcur) + delta;
    if (wsum > WB_MAX) begin
      wnew = 16'sd32767;
    end else if (wsum < WB_MIN) begin
      wnew = -16'sd32768;
    end else begin
      wnew = wsum[15:0];
    end
  end

  always_comb begin
    if (state == S_WB) begin
      w_we    = 1'b1;
      w_waddr = row_addr;
      w_wdata = wnew;
    end else begin
      w_we    = accept && (in_ch.opcode == OP_WEIGHT) && (32'(in_ch.slot) < WEIGHT_DEPTH);
      w_waddr = WA_W'(in_ch.slot);
      w_wdata = in_ch.value;
    end
  end

  pi_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  pi_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_features (
    .clk   (clk),
    .we    (f_we),
    .waddr (FA_W'(in_ch.slot)),
    .wdata (in_ch.value),
    .raddr (FA_W'(col)),
    .rdata (f_rdata)
  );

  // datapath combinational pieces
  logic signed [15:0]     w_s;
  logic signed [15:0]     f_s;
  logic signed [31:0]     fw;
  logic signed [M1_W-1:0] fd;
  logic signed [M2_W-1:0] mr;
  logic signed [ACC_W-1:0] rnd;
  logic signed [15:0]     s16;
  logic [16:0]            mag;
  logic [16:0]            tidx;
  logic [15:0]            lo;
  logic [15:0]            hi;
  logic [STEP-1:0]        frac;
  logic [16:0]            y_c;
  logic [Y_W-1:0]         yr;
  logic signed [15:0]     tres;
  logic signed [16:0]     dval;
  logic [16:0]            dabs;

  assign w_s = w_rdata;
  assign f_s = f_rdata;
  assign fw  = w_s * f_s;
  assign fd  = M1_W'(f_s) * M1_W'(diff);
  assign mr  = M2_W'(m1) * M2_W'($signed({1'b0, learn_rate}));

  always_comb begin
    rnd = (acc + ACC_HALF) >>> FRAC_BITS;
    if (rnd > ACC_MAX) begin
      s16 = 16'sd32767;
    end else if (rnd < ACC_MIN) begin
      s16 = -16'sd32768;
    end else begin
      s16 = rnd[15:0];
    end
  end

  always_comb begin
    mag  = sval[15] ? 17'(-(17'(sval))) : 17'(sval);
    tidx = mag >> STEP;
    frac = mag[STEP-1:0];
    lo   = tanh_q15(tidx[4:0]);
    hi   = tanh_q15(tidx[4:0] + 5'd1);
  end

  always_comb begin
    y_c = tsat ? 17'd32768
               : 17'(tlo) + 17'((tprod + (TP_W'(1) << (STEP - 1))) >> STEP);
    if (FRAC_BITS < 15) begin
      yr = Y_W'((ty + (17'(1) << (DN - 1))) >> DN);
    end else begin
      yr = Y_W'(ty) << UP;
    end
    if (!tneg) begin
      tres = (yr > Y_W'(32767)) ? 16'sd32767 : 16'(yr);
    end else begin
      tres = (yr > Y_W'(32768)) ? -16'sd32768 : 16'(-yr);
    end
  end

  // target minus current output and its error word
  always_comb begin
    dval = 17'(in_ch.value) - 17'(ostore[O_W'(in_ch.slot)]);
    dabs = dval[16] ? 17'(-dval) : 17'(dval);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NO_CAP; i++) begin
        ostore[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            col  <= '0;
            acc  <= '0;
            if (in_ch.opcode == OP_FEATURE && in_ch.final_req) begin
              eval     <= 1'b1;
              oidx     <= '0;
              row_base <= '0;
              state    <= S_RD;
            end else if (in_ch.opcode == OP_TARGET && 32'(in_ch.slot) < 32'(no)) begin
              eval     <= 1'b0;
              oidx     <= O_W'(in_ch.slot);
              row_base <= WA_W'(32'(in_ch.slot) * ROW_STRIDE);
              diff     <= dval;
              if (mode == MODE_REGRESSION) begin
                err <= (dabs > 17'd32767) ? 16'sd32767 : 16'(dabs);
              end else begin
                err <= ((ostore[O_W'(in_ch.slot)] > 0 && in_ch.value < 0) ||
                        (ostore[O_W'(in_ch.slot)] < 0 && in_ch.value > 0))
                       ? 16'sd1 : 16'sd0;
              end
              state    <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          wcur <= w_s;
          if (is_bias) begin
            prod <= PROD_W'(w_s) <<< FRAC_BITS;
            m1   <= M1_W'(diff);
          end else begin
            prod <= PROD_W'(fw);
            m1   <= fd;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (eval) begin
            acc <= acc + ACC_W'(prod);
            if (is_bias) begin
              state <= S_RND;
            end else begin
              col   <= col + C_W'(1);
              state <= S_RD;
            end
          end else begin
            m2    <= mr;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (is_bias) begin
            res_kind <= KIND_ERROR;
            res_idx  <= INDEX_W'(oidx);
            res_val  <= err;
            res_last <= 1'b1;
            state    <= S_EMIT;
          end else begin
            col   <= col + C_W'(1);
            state <= S_RD;
          end
        end
        S_RND: begin
          if (mode == MODE_REGRESSION) begin
            ostore[oidx] <= s16;
            res_kind <= KIND_OUTPUT;
            res_idx  <= INDEX_W'(oidx);
            res_val  <= s16;
            res_last <= (NO_W'(oidx) + NO_W'(1) == no);
            state    <= S_EMIT;
          end else begin
            sval  <= s16;
            state <= S_T1;
          end
        end
        S_T1: begin
          tsat  <= (tidx >= 17'(TANH_LAST));
          tneg  <= sval[15];
          tlo   <= lo;
          tprod <= TP_W'(hi - lo) * TP_W'(frac);
          state <= S_T2;
        end
        S_T2: begin
          ty    <= y_c;
          state <= S_T3;
        end
        S_T3: begin
          ostore[oidx] <= tres;
          res_kind <= KIND_OUTPUT;
          res_idx  <= INDEX_W'(oidx);
          res_val  <= tres;
          res_last <= (NO_W'(oidx) + NO_W'(1) == no);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            // advance to the next output row, or finish
            if (eval && !res_last) begin
              oidx     <= oidx + O_W'(1);
              row_base <= row_base + WA_W'(ROW_STRIDE);
              col      <= '0;
              acc      <= '0;
              state    <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = (state == S_EMIT);
  assign out_ch.kind         = res_kind;
  assign out_ch.out_index    = res_idx;
  assign out_ch.result_value = res_val;
  assign out_ch.run_end      = res_last;

endmodule

>>> rtl/pi_ram.sv
// ----------------------------------------------------------------------------
// pi_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
